// ===== design/mmt_pkg.sv =====
// ----------------------------------------------------------------------------
// mmt_pkg
// shared constants, codes and control types of the multiset mex tracker
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int VALUE_RANGE   = 256;
    localparam int VALUE_BITS    = $clog2(VALUE_RANGE);
    localparam int MEX_BITS      = VALUE_BITS + 1;
    localparam int COUNT_BITS    = 8;
    localparam int BIT_IDX_BITS  = 4;
    localparam int WORD_BITS     = 1 << BIT_IDX_BITS;
    localparam int WORD_IDX_BITS = VALUE_BITS - BIT_IDX_BITS;
    localparam int NUM_WORDS     = 1 << WORD_IDX_BITS;
    localparam int CMD_BITS      = 2;
    localparam int STATUS_BITS   = 2;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 16;

    localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_NOP    = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_SATURATED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT    = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UPDATE = 6'b000010,
        S_WORD   = 6'b000100,
        S_BIT    = 6'b001000,
        S_DONE   = 6'b010000,
        S_SPARE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic search_word;
        logic search_bit;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_search;
    } dp_stat_t;

endpackage

// ===== design/mmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmt_ctrl
// item sequencer: capture, count update, mex search and result handoff
// ----------------------------------------------------------------------------
module mmt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output mmt_pkg::dp_cmd_t cmd,
    input  mmt_pkg::dp_stat_t stat
);
    import mmt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = stat.need_search ? S_WORD : S_DONE;
            end
            S_WORD:
            begin
                cmd.search_word = 1'b1;
                state_next      = S_BIT;
            end
            S_BIT:
            begin
                cmd.search_bit = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !cmd.load_out)
    else $error("result overwritten while stalled");

    // a search always runs word then bit then handoff
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_word |=> (cmd.search_bit ##1 (state_reg == S_DONE)))
    else $error("search sequence broken");

endmodule

// ===== design/mmt_dpath.sv =====
// ----------------------------------------------------------------------------
// mmt_dpath
// count memory, presence bitmap, mex register and two-step zero search
// ----------------------------------------------------------------------------
module mmt_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mmt_pkg::CMD_BITS-1:0]        command,
    input  logic [mmt_pkg::VALUE_BITS-1:0]      value,
    input  mmt_pkg::dp_cmd_t                    cmd,
    output mmt_pkg::dp_stat_t                   stat,
    output logic [mmt_pkg::OUT_DATA_BITS-1:0]   out_data
);
    import mmt_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] counts [VALUE_RANGE];

    logic [NUM_WORDS-1:0][WORD_BITS-1:0] present_reg;
    logic [NUM_WORDS-1:0][WORD_BITS-1:0] present_next;
    logic [MEX_BITS-1:0]                 mex_reg;
    logic [MEX_BITS-1:0]                 mex_next;
    logic [STATUS_BITS-1:0]              status_reg;
    logic [STATUS_BITS-1:0]              status_next;
    logic [CMD_BITS-1:0]                 item_cmd_reg;
    logic [VALUE_BITS-1:0]               item_val_reg;
    logic [COUNT_BITS-1:0]               rd_cnt_reg;
    logic [WORD_IDX_BITS-1:0]            word_idx_reg;
    logic                                all_full_reg;
    logic [MEX_BITS-1:0]                 out_mex_reg;
    logic [STATUS_BITS-1:0]              out_status_reg;

    logic [WORD_IDX_BITS-1:0] item_word;
    logic [BIT_IDX_BITS-1:0]  item_bit;
    logic [COUNT_BITS-1:0]    cnt_cur;
    logic                     wr_en;
    logic [COUNT_BITS-1:0]    wr_cnt;
    logic [NUM_WORDS-1:0]     word_full;
    logic [WORD_IDX_BITS-1:0] free_word;
    logic [WORD_BITS-1:0]     sel_word;
    logic [BIT_IDX_BITS-1:0]  free_bit;

    assign item_word = item_val_reg[VALUE_BITS-1:BIT_IDX_BITS];
    assign item_bit  = item_val_reg[BIT_IDX_BITS-1:0];
    assign cnt_cur   = present_reg[item_word][item_bit] ? rd_cnt_reg : '0;

    // first word with a free slot
    always_comb
    begin
        free_word = '0;
        for (int w = NUM_WORDS - 1; w >= 0; w--)
        begin
            word_full[w] = &present_reg[w];
            if (!word_full[w])
            begin
                free_word = WORD_IDX_BITS'(w);
            end
        end
    end

    // first free slot in the chosen word
    always_comb
    begin
        sel_word = present_reg[word_idx_reg];
        free_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!sel_word[b])
            begin
                free_bit = BIT_IDX_BITS'(b);
            end
        end
    end

    always_comb
    begin
        present_next     = present_reg;
        mex_next         = mex_reg;
        status_next      = status_reg;
        wr_en            = 1'b0;
        wr_cnt           = cnt_cur;
        stat.need_search = 1'b0;
        if (cmd.update)
        begin
            unique case (item_cmd_reg)
                CMD_ADD:
                begin
                    if (cnt_cur == COUNT_MAX)
                    begin
                        status_next = ST_SATURATED;
                    end
                    else
                    begin
                        status_next                      = ST_OK;
                        wr_en                            = 1'b1;
                        wr_cnt                           = cnt_cur + COUNT_ONE;
                        present_next[item_word][item_bit] = 1'b1;
                        stat.need_search = !mex_reg[MEX_BITS-1] &&
                                           (item_val_reg == mex_reg[VALUE_BITS-1:0]);
                    end
                end
                CMD_REMOVE:
                begin
                    if (cnt_cur == '0)
                    begin
                        status_next = ST_ABSENT;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        wr_en       = 1'b1;
                        wr_cnt      = cnt_cur - COUNT_ONE;
                        if (cnt_cur == COUNT_ONE)
                        begin
                            present_next[item_word][item_bit] = 1'b0;
                            if ({1'b0, item_val_reg} < mex_reg)
                            begin
                                mex_next = {1'b0, item_val_reg};
                            end
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    status_next  = ST_OK;
                    present_next = '0;
                    mex_next     = '0;
                end
                CMD_NOP:
                begin
                    status_next = ST_OK;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        if (cmd.search_bit)
        begin
            mex_next = all_full_reg ? MEX_BITS'(VALUE_RANGE)
                                    : {1'b0, word_idx_reg, free_bit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_cnt_reg <= counts[value];
        end
        if (wr_en)
        begin
            counts[item_val_reg] <= wr_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_cmd_reg <= command;
            item_val_reg <= value;
        end
        if (cmd.search_word)
        begin
            word_idx_reg <= free_word;
            all_full_reg <= &word_full;
        end
        if (cmd.load_out)
        begin
            out_mex_reg    <= mex_reg;
            out_status_reg <= status_reg;
        end
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            mex_reg     <= '0;
        end
        else
        begin
            present_reg <= present_next;
            mex_reg     <= mex_next;
        end
    end

    assign out_data = {(OUT_DATA_BITS - MEX_BITS - STATUS_BITS)'(0), out_status_reg, out_mex_reg};

    // between items every value below the mex is present and the mex itself is not
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && !mex_reg[MEX_BITS-1]) |->
        !present_reg[mex_reg[VALUE_BITS-1:BIT_IDX_BITS]][mex_reg[BIT_IDX_BITS-1:0]])
    else $error("mex points at a present value");

    assert property (@(posedge clk) disable iff (!rst_n)
        mex_reg <= MEX_BITS'(VALUE_RANGE))
    else $error("mex beyond value range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && item_cmd_reg == CMD_CLEAR) |=> (mex_reg == '0 && present_reg == '0))
    else $error("clear left state behind");

endmodule

// ===== design/multiset_mex_tracker_top.sv =====
// ----------------------------------------------------------------------------
// multiset_mex_tracker_top
// occurrence counts of a value multiset with its least absent value (mex)
//
// channel  dir  beat contents (low bit first)
// s_*      in   tdata: command[1:0], value[9:2], zero pad
// m_*      out  tdata: mex[8:0], status[10:9], zero pad
//
// one item at a time: after accept the item passes the update and done states,
// and the result register is loaded from done; when an add fills the slot at the
// mex, the two-step bitmap search (word, then bit) runs between update and done;
// the next item is accepted the cycle after the result is loaded.
// reset empties the store at once through the presence bitmap, no sweep.
// a stalled result holds in the output register; a new item is still taken
// and waits before handoff until that result leaves.
// ----------------------------------------------------------------------------
module multiset_mex_tracker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mmt_pkg::IN_DATA_BITS-1:0]    s_tdata,   // command, value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmt_pkg::OUT_DATA_BITS-1:0]   m_tdata    // mex, status
);
    import mmt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mmt_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .command  (s_tdata[CMD_BITS-1:0]),
        .value    (s_tdata[CMD_BITS+VALUE_BITS-1:CMD_BITS]),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule
